### rtl/assert_macros.svh
// Assertion helpers for the cipher core.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/chacha_pkg.sv
package chacha_pkg;

    localparam int WORD_W            = 32;
    localparam int KS_WORDS          = 16;
    localparam int KS_AW             = 5;   // bank bit and word index
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int DEF_DOUBLE_ROUNDS = 10;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [KS_WORDS-1:0][WORD_W-1:0] t_block;
    typedef logic [3:0][WORD_W-1:0] t_quad;

    // "expand 32-byte k", little-endian words
    localparam t_word SIGMA_0 = 32'h6170_7865;
    localparam t_word SIGMA_1 = 32'h3320_646e;
    localparam t_word SIGMA_2 = 32'h7962_2d32;
    localparam t_word SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_0,
        CFG_KEY_1,
        CFG_KEY_2,
        CFG_KEY_3,
        CFG_NONCE_LO,
        CFG_NONCE_HI,
        CFG_INIT_CTR
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [63:0]      nonce_lo;
        t_word            nonce_hi;
    } t_key_cfg;

    typedef struct packed {
        logic  start;
        logic  bank;
        t_word ctr;
    } t_gen_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_gen_stat;

    typedef struct packed {
        logic             we;
        logic [KS_AW-1:0] addr;
        t_word            data;
    } t_ks_wr;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic [1:0] lane;
    } t_beat;

    // One half of a quarter round: rotations 16/12 for the first half, 8/7 for the second.
    function automatic t_quad half_qr(t_word a, t_word b, t_word c, t_word d, logic second);
        t_word a1;
        t_word b1;
        t_word c1;
        t_word d1;
        t_word dx;
        t_word bx;
        t_quad q;
        a1 = a + b;
        dx = d ^ a1;
        d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
        c1 = c + d1;
        bx = b ^ c1;
        b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
        q[0] = a1;
        q[1] = b1;
        q[2] = c1;
        q[3] = d1;
        return q;
    endfunction

endpackage

### rtl/chacha_ks_ram.sv
module chacha_ks_ram (
    input  logic                        i_clk,
    input  chacha_pkg::t_ks_wr          i_wr,
    input  logic                        i_rd_en,
    input  logic [chacha_pkg::KS_AW-1:0] i_rd_addr,
    output chacha_pkg::t_word           o_rd_data
);
    import chacha_pkg::*;

    // Two banks of keystream words: one drains while the other fills.
    t_word r_mem [2**KS_AW];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/chacha_gen.sv
module chacha_gen #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DEF_DOUBLE_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  chacha_pkg::t_key_cfg i_cfg,
    input  chacha_pkg::t_gen_req i_req,
    output chacha_pkg::t_gen_stat o_stat,
    output chacha_pkg::t_ks_wr   o_wr
);
    import chacha_pkg::*;

    localparam int STEPS = 4 * DOUBLE_ROUNDS;
    localparam int SW    = $clog2(STEPS);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_WRITE} t_state;

    t_state        r_state;
    logic [SW-1:0] r_step;
    logic [3:0]    r_widx;
    t_block        r_work;
    t_word         r_ctr;
    logic          r_bank;
    t_block        n_work;
    t_block        init_blk;

    function automatic t_block init_block(t_key_cfg cfg, t_word ctr);
        t_block blk;
        blk[0] = SIGMA_0;
        blk[1] = SIGMA_1;
        blk[2] = SIGMA_2;
        blk[3] = SIGMA_3;
        for (int k = 0; k < 4; k++) begin
            blk[4 + 2 * k] = cfg.key[k][31:0];
            blk[5 + 2 * k] = cfg.key[k][63:32];
        end
        blk[12] = ctr;
        blk[13] = cfg.nonce_lo[31:0];
        blk[14] = cfg.nonce_lo[63:32];
        blk[15] = cfg.nonce_hi;
        return blk;
    endfunction

    // Four quarter-round lanes, half a quarter round per cycle.
    // Step bit 0 picks the half, bit 1 picks column or diagonal pairing.
    always_comb begin
        logic       dg;
        logic [1:0] li;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        t_quad      q;
        n_work = r_work;
        dg     = r_step[1];
        for (int i = 0; i < 4; i++) begin
            li = 2'(i);
            ia = {2'b00, li};
            ib = {2'b01, li + {1'b0, dg}};
            ic = {2'b10, li + {dg, 1'b0}};
            id = {2'b11, li + {dg, dg}};
            q  = half_qr(r_work[ia], r_work[ib], r_work[ic], r_work[id], r_step[0]);
            n_work[ia] = q[0];
            n_work[ib] = q[1];
            n_work[ic] = q[2];
            n_work[id] = q[3];
        end
    end

    assign init_blk = init_block(i_cfg, r_ctr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_widx  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_work  <= init_block(i_cfg, i_req.ctr);
                        r_ctr   <= i_req.ctr;
                        r_bank  <= i_req.bank;
                        r_step  <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_work <= n_work;
                    if (r_step == SW'(STEPS - 1)) begin
                        r_widx  <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_step <= r_step + SW'(1);
                    end
                end
                S_WRITE: begin
                    r_widx <= r_widx + 4'd1;
                    if (r_widx == 4'hf) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Feed-forward add, one word per cycle into the target bank.
    assign o_wr.we   = (r_state == S_WRITE);
    assign o_wr.addr = {r_bank, r_widx};
    assign o_wr.data = r_work[r_widx] + init_blk[r_widx];

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_WRITE) && (r_widx == 4'hf);

endmodule

### rtl/chacha_xor.sv
module chacha_xor (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  chacha_pkg::t_beat i_beat,
    input  chacha_pkg::t_word i_rd_data,
    input  logic              i_m_tready,
    output logic              o_free,
    output logic              o_m_tvalid,
    output logic [7:0]        o_m_tdata,
    output logic              o_m_tlast
);
    import chacha_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_data;
    logic       r_s1_last;
    logic [1:0] r_s1_lane;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;
    logic       out_free;
    logic [7:0] ks_byte;

    assign out_free = !r_out_valid || i_m_tready;
    assign o_free   = !r_s1_valid || out_free;
    assign ks_byte  = i_rd_data[{r_s1_lane, 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
            if (o_free) begin
                r_s1_valid <= i_beat.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && out_free) begin
            r_out_data <= r_s1_data ^ ks_byte;
            r_out_last <= r_s1_last;
        end
        if (o_free && i_beat.valid) begin
            r_s1_data <= i_beat.data;
            r_s1_last <= i_beat.last;
            r_s1_lane <= i_beat.lane;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

### rtl/chacha20_stream_cipher_top.sv
// Channel  Dir  Handshake                        Payload
// s_axis   in   s_axis_tvalid / s_axis_tready    tdata[7:0] data_byte, tlast last_of_message
// m_axis   out  m_axis_tvalid / m_axis_tready    tdata[7:0] result_byte, tlast result_last
// cfg      in   i_cfg_valid / o_cfg_ready        i_cfg_index register, i_cfg_data value
//
// Sustained rate is one byte per cycle while the output does not stall: the round engine
// fills the idle keystream bank while the other bank drains over 64 bytes.
// A message's first byte waits until its block is generated, and also for a dropped
// block still running to finish. Reset is synchronous.
// An output stall holds the two-stage byte path; input keeps flowing while a stage is free.
// A config write in mid-message discards the prefetched block and remakes it.
module chacha20_stream_cipher_top #(
    parameter int DOUBLE_ROUNDS = chacha_pkg::DEF_DOUBLE_ROUNDS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,   // [7:0] result_byte
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [chacha_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [chacha_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import chacha_pkg::*;

    localparam logic [5:0] POS_LAST = 6'd63;

    // Configuration registers
    t_key_cfg r_cfg;
    t_word    r_init_ctr;

    // Message and bank control
    logic       r_fresh;
    logic [5:0] r_pos;
    logic       r_cur;
    logic [1:0] r_full;
    t_word      r_cur_ctr;
    logic       r_drop;
    logic       r_gen_bank;

    logic       n_fresh;
    logic [5:0] n_pos;
    logic       n_cur;
    logic [1:0] n_full;
    t_word      n_cur_ctr;
    logic       n_drop;
    logic       n_gen_bank;

    logic      cfg_we;
    logic      accept;
    logic      is_end;
    logic      xor_free;
    t_word     base_ctr;
    t_gen_req  gen_req;
    t_gen_stat gen_stat;
    t_ks_wr    ks_wr;
    t_word     rd_data;
    t_beat     beat;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Take a byte only when its keystream bank is complete.
    assign s_axis_tready = r_full[r_cur] && xor_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_end        = accept && (s_axis_tlast || (r_pos == POS_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= '0;
            r_init_ctr <= 32'd1;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KEY_0:    r_cfg.key[0]   <= i_cfg_data;
                CFG_KEY_1:    r_cfg.key[1]   <= i_cfg_data;
                CFG_KEY_2:    r_cfg.key[2]   <= i_cfg_data;
                CFG_KEY_3:    r_cfg.key[3]   <= i_cfg_data;
                CFG_NONCE_LO: r_cfg.nonce_lo <= i_cfg_data;
                CFG_NONCE_HI: r_cfg.nonce_hi <= i_cfg_data[31:0];
                CFG_INIT_CTR: r_init_ctr     <= i_cfg_data[31:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    // Block scheduling: fill the current bank first, then prefetch the other.
    // Hold off a start in any cycle that moves the counter or the key.
    assign base_ctr = r_fresh ? r_init_ctr : r_cur_ctr;

    always_comb begin
        gen_req.start = !gen_stat.busy && !cfg_we && !is_end && !(&r_full);
        gen_req.bank  = r_full[r_cur] ? ~r_cur : r_cur;
        gen_req.ctr   = r_full[r_cur] ? base_ctr + 32'd1 : base_ctr;
    end

    always_comb begin
        n_fresh    = r_fresh;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_full     = r_full;
        n_cur_ctr  = r_cur_ctr;
        n_drop     = r_drop;
        n_gen_bank = r_gen_bank;

        if (gen_req.start) begin
            n_drop     = 1'b0;
            n_gen_bank = gen_req.bank;
        end
        // Mark the bank complete unless its block went stale while in flight.
        if (gen_stat.done && !r_drop && !cfg_we) begin
            n_full[r_gen_bank] = 1'b1;
        end
        if (accept) begin
            n_pos   = r_pos + 6'd1;
            n_fresh = 1'b0;
            if (r_fresh) begin
                n_cur_ctr = r_init_ctr;
            end
            if (s_axis_tlast) begin
                // Rearm: next byte starts over from the configured counter.
                n_fresh = 1'b1;
                n_pos   = '0;
                n_full  = '0;
                n_drop  = 1'b1;
            end else if (r_pos == POS_LAST) begin
                // Advance to the prefetched bank and release the drained one.
                n_cur         = ~r_cur;
                n_full[r_cur] = 1'b0;
                n_cur_ctr     = r_cur_ctr + 32'd1;
            end
        end
        if (cfg_we) begin
            // Key or nonce may have changed: drop every block not yet in use.
            n_drop = 1'b1;
            if (r_fresh) begin
                n_full = '0;
            end else begin
                n_full[~r_cur] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh    <= 1'b1;
            r_pos      <= '0;
            r_cur      <= 1'b0;
            r_full     <= '0;
            r_cur_ctr  <= '0;
            r_drop     <= 1'b0;
            r_gen_bank <= 1'b0;
        end else begin
            r_fresh    <= n_fresh;
            r_pos      <= n_pos;
            r_cur      <= n_cur;
            r_full     <= n_full;
            r_cur_ctr  <= n_cur_ctr;
            r_drop     <= n_drop;
            r_gen_bank <= n_gen_bank;
        end
    end

    chacha_gen #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (gen_req),
        .o_stat  (gen_stat),
        .o_wr    (ks_wr)
    );

    // Generator writes only a bank that is not full; reads only hit a full bank,
    // so the two ports never touch the same entry in one cycle.
    chacha_ks_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ks_wr),
        .i_rd_en   (accept),
        .i_rd_addr ({r_cur, r_pos[5:2]}),
        .o_rd_data (rd_data)
    );

    always_comb begin
        beat.valid = accept;
        beat.data  = s_axis_tdata;
        beat.last  = s_axis_tlast;
        beat.lane  = r_pos[1:0];
    end

    chacha_xor u_xor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (beat),
        .i_rd_data  (rd_data),
        .i_m_tready (m_axis_tready),
        .o_free     (xor_free),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_wr_free_bank, ks_wr.we, !r_full[ks_wr.addr[KS_AW-1]], "write into full bank")
    `ASSERT_IMPLIES(a_fresh_pos, r_fresh, r_pos == '0, "message start off block boundary")
    `ASSERT_NEXT(a_last_rearm, accept && s_axis_tlast, r_fresh && (r_full == 2'b00), "no rearm")

endmodule

### tb/chacha20_stream_cipher_top_tb.sv
module chacha20_stream_cipher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chacha_pkg::*;

    localparam int N_DOUBLE_ROUNDS = 10;
    // Random stimulus stops once this many bytes have gone in
    localparam int N_RANDOM_BYTES  = 700;
    localparam int DRAIN_CYCLES    = 20;

    // Index 7 maps to no register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = {CFG_IDX_W{1'b1}};

    // "expand 32-byte k" as little-endian words
    localparam logic [31:0] EXPAND_W0 = 32'h6170_7865;
    localparam logic [31:0] EXPAND_W1 = 32'h3320_646e;
    localparam logic [31:0] EXPAND_W2 = 32'h7962_2d32;
    localparam logic [31:0] EXPAND_W3 = 32'h6b20_6574;

    localparam logic [31:0] CTR_MAX = 32'hffff_ffff;

    // One byte beat on either stream: payload byte and its last flag
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_beat_t;

    // Keystream predictor plus the queue of cipher bytes still owed by the block
    class cipher_scoreboard;
        bit [63:0]    key_reg[4];
        bit [63:0]    nonce_lo;
        bit [31:0]    nonce_hi;
        bit [31:0]    start_ctr;
        bit [31:0]    ks_words[16];
        bit [31:0]    work[16];
        bit [31:0]    next_ctr;
        bit [5:0]     ks_pos;
        bit           msg_fresh;
        cipher_beat_t cipher_q[$];
        int           fail_count;

        function new();
            foreach (key_reg[k]) key_reg[k] = '0;
            foreach (ks_words[k]) ks_words[k] = '0;
            nonce_lo   = '0;
            nonce_hi   = '0;
            start_ctr  = 32'd1;
            next_ctr   = '0;
            ks_pos     = '0;
            msg_fresh  = 1'b1;
            fail_count = 0;
        endfunction

        function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3: key_reg[idx] = value;
                CFG_NONCE_LO: nonce_lo  = value;
                CFG_NONCE_HI: nonce_hi  = value[31:0];
                CFG_INIT_CTR: start_ctr = value[31:0];
                default: ;  // unmapped index, drop it
            endcase
        endfunction

        function bit [31:0] rotl(bit [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void qround(int a, int b, int c, int d);
            work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
            work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
            work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
            work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
        endfunction

        // Build the next 64-byte keystream block from the live key and nonce
        function void refill_keystream();
            bit [31:0] init[16];
            init[0] = EXPAND_W0;
            init[1] = EXPAND_W1;
            init[2] = EXPAND_W2;
            init[3] = EXPAND_W3;
            for (int k = 0; k < 4; k++) begin
                init[4 + 2 * k] = key_reg[k][31:0];
                init[5 + 2 * k] = key_reg[k][63:32];
            end
            init[12] = next_ctr;
            init[13] = nonce_lo[31:0];
            init[14] = nonce_lo[63:32];
            init[15] = nonce_hi;
            work = init;
            for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
                qround(0, 4, 8, 12);
                qround(1, 5, 9, 13);
                qround(2, 6, 10, 14);
                qround(3, 7, 11, 15);
                qround(0, 5, 10, 15);
                qround(1, 6, 11, 12);
                qround(2, 7, 8, 13);
                qround(3, 4, 9, 14);
            end
            for (int k = 0; k < 16; k++) ks_words[k] = work[k] + init[k];
            next_ctr = next_ctr + 32'd1;  // wraps modulo 2^32
        endfunction

        // Note one accepted plaintext beat and queue the cipher byte it must produce
        function void take_plain_byte(logic [7:0] data, logic last);
            bit [31:0]    word;
            cipher_beat_t exp_beat;
            if (msg_fresh) begin
                next_ctr  = start_ctr;
                ks_pos    = '0;
                msg_fresh = 1'b0;
                refill_keystream();
            end else if (ks_pos == 0) begin
                refill_keystream();
            end
            word          = ks_words[ks_pos[5:2]];
            exp_beat.data = data ^ word[ks_pos[1:0] * 8 +: 8];
            exp_beat.last = last;
            cipher_q.push_back(exp_beat);
            ks_pos = ks_pos + 6'd1;
            if (last) msg_fresh = 1'b1;
        endfunction

        // Compare one accepted output beat with the oldest queued cipher byte
        function void match_cipher_byte(logic [7:0] data, logic last);
            cipher_beat_t exp_beat;
            if (cipher_q.size() == 0) begin
                $error("result_byte: no beat expected, got %02h (last %0b)", data, last);
                fail_count++;
                return;
            end
            exp_beat = cipher_q.pop_front();
            if (data !== exp_beat.data) begin
                $error("result_byte: expected %02h, got %02h", exp_beat.data, data);
                fail_count++;
            end
            if (last !== exp_beat.last) begin
                $error("result_last: expected %0b, got %0b", exp_beat.last, last);
                fail_count++;
            end
        endfunction

        function int pending();
            return cipher_q.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] data_byte
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [7:0] result_byte
    logic                  m_axis_tlast;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    cipher_scoreboard sb;
    // Per-phase switches that turn random idling off on one side
    bit               sender_quiet;
    bit               receiver_quiet;
    int               random_sent;
    int               phase;

    chacha20_stream_cipher_top #(
        .DOUBLE_ROUNDS (N_DOUBLE_ROUNDS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Write one register; drop valid afterwards so the next write starts on a new edge
    task automatic write_cfg_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.apply_reg_write(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one plaintext beat; valid stays high afterwards unless the next call idles
    task automatic send_plain_byte(logic [7:0] data, logic last);
        int gap;
        gap = pick_gap(sender_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_plain_byte(data, last);
    endtask

    // Send len random bytes; mark the final one last only when the message closes
    task automatic send_message(int len, bit close);
        for (int k = 0; k < len; k++)
            send_plain_byte(8'($urandom), close && (k == len - 1));
    endtask

    // Hold off the sender until every owed cipher byte has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic [63:0] value, logic [31:0] ctr);
        for (int r = CFG_KEY_0; r <= CFG_NONCE_HI; r++)
            write_cfg_reg(CFG_IDX_W'(r), value);
        write_cfg_reg(CFG_INIT_CTR, {32'($urandom), ctr});
    endtask

    // Pick a fresh setting for a random phase; the first phases pin the counter extremes
    task automatic configure_phase(int ph);
        logic [31:0] ctr;
        case (ph)
            0:       ctr = CTR_MAX;
            1:       ctr = '0;
            2:       ctr = CTR_MAX - 32'd1;
            default: ctr = ($urandom_range(0, 3) == 0) ? CTR_MAX - 32'($urandom_range(0, 2))
                                                       : 32'($urandom);
        endcase
        for (int r = CFG_KEY_0; r <= CFG_NONCE_HI; r++)
            if (ph < 3 || $urandom_range(0, 2) != 0)
                write_cfg_reg(CFG_IDX_W'(r), {32'($urandom), 32'($urandom)});
        if (ph < 3 || $urandom_range(0, 1) != 0)
            write_cfg_reg(CFG_INIT_CTR, {32'($urandom), ctr});
        if ($urandom_range(0, 7) == 0)
            write_cfg_reg(CFG_IDX_SPARE, {32'($urandom), 32'($urandom)});
    endtask

    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 24);
        if (r < 90) return $urandom_range(25, 80);
        return $urandom_range(81, 160);
    endfunction

    // Watchdog: end the run if the stream stalls for good
    initial begin
        #2_000_000;
        $display("chacha20_stream_cipher_top: mismatch");
        $finish;
    end

    initial begin
        int n_msgs;
        int len;
        bit close;

        sb             = new();
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        random_sent    = 0;

        // Hold reset, then release it once for the whole run
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Receiver: stall at random, check every beat taken
        fork
            forever begin
                int gap;
                gap = pick_gap(receiver_quiet);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                do @(posedge i_clk); while (!m_axis_tvalid);
                sb.match_cipher_byte(m_axis_tdata, m_axis_tlast);
            end
        join_none

        // Reset setting: zero key and nonce, counter one; extreme bytes and a lone byte
        send_plain_byte(8'h00, 1'b0);
        send_plain_byte(8'hff, 1'b0);
        send_plain_byte(8'h5a, 1'b1);
        send_plain_byte(8'hff, 1'b1);
        wait_drained();

        // All ones everywhere, counter at its top; the unmapped index must not disturb it
        write_all_regs('1, CTR_MAX);
        write_cfg_reg(CFG_IDX_SPARE, 64'h0123_4567_89ab_cdef);
        send_plain_byte(8'h00, 1'b0);
        send_plain_byte(8'hff, 1'b1);
        send_message(4, 1'b0);
        wait_drained();

        // Change key and start counter in mid-message: the open block keeps its
        // keystream and the counter change waits for the next message
        write_cfg_reg(CFG_KEY_2, 64'hdead_beef_0bad_f00d);
        write_cfg_reg(CFG_INIT_CTR, '0);
        send_message(2, 1'b1);
        send_plain_byte(8'ha5, 1'b1);
        wait_drained();

        // All zero with counter zero
        write_all_regs('0, '0);
        send_plain_byte(8'h3c, 1'b1);
        send_message(3, 1'b1);
        wait_drained();

        // Random phases: new setting, a few messages, sometimes one left open, then drain
        phase = 0;
        while (random_sent < N_RANDOM_BYTES) begin
            configure_phase(phase);
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
            n_msgs         = $urandom_range(1, 4);
            for (int m = 0; m < n_msgs; m++) begin
                // Early phases cross block boundaries so the counter wraps
                len   = (phase < 3 && m == 0) ? 130 : pick_msg_len();
                close = (m < n_msgs - 1) || ($urandom_range(0, 4) != 0);
                send_message(len, close);
                random_sent += len;
            end
            wait_drained();
            phase++;
        end

        // Let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("chacha20_stream_cipher_top: match");
        end else begin
            $display("chacha20_stream_cipher_top: mismatch");
        end
        $finish;
    end

endmodule
